FILE: sv/c4rp_pkg.sv
// Shared constants, queue entry type and codeword function of the CRC-4 row packer.
package c4rp_pkg;

  localparam int CODEWORDS_PER_ROW = 5;
  localparam int ROWS_PER_FRAME    = 60;

  localparam int BYTE_W    = 8;
  localparam int CRC_W     = 4;
  localparam int CW_WIDTH  = BYTE_W + CRC_W;
  localparam int ROW_WIDTH = 60;
  localparam int ROW_NUM_W = 6;
  localparam int FRAME_W   = 16;
  localparam int SLOT_W    = $clog2(CODEWORDS_PER_ROW + 1);

  // Generator x^4 + x + 1.
  localparam logic [CW_WIDTH-1:0] CRC_POLY = CW_WIDTH'(5'b10011);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  typedef struct packed {
    logic                is_flush;
    logic [CW_WIDTH-1:0] codeword;
  } q_entry_t;

  // Data byte followed by the remainder of byte * x^4 mod the generator.
  function automatic logic [CW_WIDTH-1:0] make_codeword(input logic [BYTE_W-1:0] data);
    logic [CW_WIDTH-1:0] rem;
    rem = {data, {CRC_W{1'b0}}};
    for (int b = CW_WIDTH - 1; b >= CRC_W; b--) begin
      if (rem[b]) begin
        rem = rem ^ (CRC_POLY << (b - CRC_W));
      end
    end
    return {data, rem[CRC_W-1:0]};
  endfunction

endpackage

FILE: sv/c4rp_if.sv
// Handshake interfaces for the byte requests and the row results.
interface c4rp_byte_if;
  import c4rp_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_byte;

  modport source(output valid, action, data_byte, input ready);
  modport sink(input valid, action, data_byte, output ready);
endinterface

interface c4rp_row_if;
  import c4rp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ROW_WIDTH-1:0] row_bits;
  logic [ROW_NUM_W-1:0] row_number;
  logic [FRAME_W-1:0]   frame_number;
  logic                 end_of_frame;

  modport source(output valid, row_bits, row_number, frame_number, end_of_frame,
                 input ready);
  modport sink(input valid, row_bits, row_number, frame_number, end_of_frame,
               output ready);
endinterface

FILE: sv/c4rp_front.sv
// Front end: accepts requests, classifies them and builds the CRC-4 codeword.
module c4rp_front (
  c4rp_byte_if.sink           byte_stream,
  output logic                push_valid,
  output c4rp_pkg::q_entry_t  push_entry,
  input  logic                push_ready
);
  import c4rp_pkg::*;

  assign byte_stream.ready = push_ready;
  assign push_valid        = byte_stream.valid;

  always_comb begin
    push_entry.is_flush = (action_t'(byte_stream.action) == ACT_FLUSH);
    push_entry.codeword = make_codeword(byte_stream.data_byte);
  end

endmodule

FILE: sv/c4rp_queue.sv
// Small first-in first-out queue between the front end and the packer.
module c4rp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  c4rp_pkg::q_entry_t  push_entry,
  output logic                push_ready,
  output logic                head_valid,
  output c4rp_pkg::q_entry_t  head,
  input  logic                head_pop
);
  import c4rp_pkg::*;

  q_entry_t          entries [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_CW-1:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != Q_CW'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

FILE: sv/c4rp_back.sv
// Back end: packs codewords into rows, counts rows and frames, holds the result register.
module c4rp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  c4rp_pkg::q_entry_t  head,
  output logic                head_pop,
  c4rp_row_if.source          row_stream
);
  import c4rp_pkg::*;

  logic [ROW_WIDTH-1:0] row_buffer;
  logic [SLOT_W-1:0]    slot_count;
  logic [ROW_NUM_W-1:0] row_count;
  logic [FRAME_W-1:0]   frame_count;

  logic [ROW_WIDTH-1:0] row_buffer_next;
  logic [SLOT_W-1:0]    slot_count_next;
  logic [ROW_NUM_W-1:0] row_count_next;
  logic [FRAME_W-1:0]   frame_count_next;

  logic                 out_valid;
  logic [ROW_WIDTH-1:0] out_bits;
  logic [ROW_NUM_W-1:0] out_row;
  logic [FRAME_W-1:0]   out_frame;
  logic                 out_eof;

  logic                 take;
  logic                 emit;
  logic                 emit_eof;
  logic [ROW_WIDTH-1:0] filled;
  logic                 last_slot;
  logic                 last_row;

  assign take     = head_valid && (!out_valid || row_stream.ready);
  assign head_pop = take;

  assign last_slot = (slot_count >= SLOT_W'(CODEWORDS_PER_ROW - 1));
  assign last_row  = (row_count >= ROW_NUM_W'(ROWS_PER_FRAME - 1));

  // Drop the new codeword into the slot selected by slot_count.
  always_comb begin
    filled = row_buffer;
    for (int i = 0; i < CODEWORDS_PER_ROW; i++) begin
      if (slot_count == SLOT_W'(i)) begin
        filled[ROW_WIDTH-1-i*CW_WIDTH -: CW_WIDTH] = head.codeword;
      end
    end
  end

  always_comb begin
    row_buffer_next  = row_buffer;
    slot_count_next  = slot_count;
    row_count_next   = row_count;
    frame_count_next = frame_count;
    emit             = 1'b0;
    emit_eof         = 1'b0;
    if (head.is_flush) begin
      if (slot_count != '0) begin
        emit             = 1'b1;
        emit_eof         = 1'b1;
        row_buffer_next  = '0;
        slot_count_next  = '0;
        row_count_next   = '0;
        frame_count_next = frame_count + 1'b1;
      end else if (row_count != '0) begin
        row_count_next   = '0;
        frame_count_next = frame_count + 1'b1;
      end
    end else if (last_slot) begin
      emit            = 1'b1;
      emit_eof        = last_row;
      row_buffer_next = '0;
      slot_count_next = '0;
      if (last_row) begin
        row_count_next   = '0;
        frame_count_next = frame_count + 1'b1;
      end else begin
        row_count_next = row_count + 1'b1;
      end
    end else begin
      row_buffer_next = filled;
      slot_count_next = slot_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_buffer  <= '0;
      slot_count  <= '0;
      row_count   <= '0;
      frame_count <= FRAME_W'(1);
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        row_buffer  <= row_buffer_next;
        slot_count  <= slot_count_next;
        row_count   <= row_count_next;
        frame_count <= frame_count_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (row_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A flush sends the partial row as it stands; the codeword in its entry is not packed.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_bits  <= head.is_flush ? row_buffer : filled;
      out_row   <= row_count;
      out_frame <= frame_count;
      out_eof   <= emit_eof;
    end
  end

  assign row_stream.valid        = out_valid;
  assign row_stream.row_bits     = out_bits;
  assign row_stream.row_number   = out_row;
  assign row_stream.frame_number = out_frame;
  assign row_stream.end_of_frame = out_eof;

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count < SLOT_W'(CODEWORDS_PER_ROW))
    else $error("slot count out of range");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_count < ROW_NUM_W'(ROWS_PER_FRAME))
    else $error("row count out of range");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (take && emit) |=> out_valid)
    else $error("emitted row not registered");

  a_eof_closes: assert property (@(posedge clk) disable iff (rst)
    (take && emit_eof) |=> (row_count == '0 && slot_count == '0 &&
                            frame_count == $past(frame_count) + 1'b1))
    else $error("frame not closed after end-of-frame row");

endmodule

FILE: sv/crc4_codeword_row_packer.sv
// Top level of the CRC-4 codeword row packer: front end, queue and packing back end.
//
//   Channel      Dir  Handshake      Payload
//   byte_stream  in   valid/ready    action (1), data_byte (8)
//   row_stream   out  valid/ready    row_bits (60), row_number (6),
//                                    frame_number (16), end_of_frame (1)
//
// One request is accepted per cycle while the queue has room; a request reaches the
// packer in the cycle after it enters the queue at the earliest, and a completed row
// appears on row_stream the cycle after the packer consumes the request that finishes it.
// Throughput is set by the packer, which retires one queue entry per cycle while its
// result register is empty or being drained.
// rst is synchronous; it empties the queue, clears the row buffer and the row count,
// and sets the frame number to one.
// When row_stream stalls, the packer holds; the four-entry queue keeps taking requests
// until it fills, and only then does byte_stream.ready drop.
module crc4_codeword_row_packer (
  input  logic        clk,
  input  logic        rst,
  c4rp_byte_if.sink   byte_stream,
  c4rp_row_if.source  row_stream
);
  import c4rp_pkg::*;

  // Front end to queue.
  logic     push_valid;
  logic     push_ready;
  q_entry_t push_entry;

  // Queue head to packer.
  logic     head_valid;
  logic     head_pop;
  q_entry_t head;

  // The front end works out the codeword in the same cycle the request is accepted,
  // so the queue only ever holds finished codewords and flush markers.
  c4rp_front u_front (
    .byte_stream (byte_stream),
    .push_valid  (push_valid),
    .push_entry  (push_entry),
    .push_ready  (push_ready)
  );

  c4rp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // The back end owns all row and frame state and the result register.
  c4rp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .row_stream (row_stream)
  );

endmodule
